>>> hdl/mmc_pkg.sv
// shared types, constants and helpers of the magnetometer min/max calibration core
package mmc_pkg;

   localparam int RawBitsDefault = 16;

   localparam int CosW     = 15;
   localparam int TimeoutW = 16;
   localparam int RadiusW  = 12;
   localparam int TiltW    = 16;
   localparam int RateW    = 16;
   localparam int TickW    = 8;
   localparam int CorrW    = 32;
   localparam int IndW     = 3;
   localparam int GainW    = 23;
   localparam int AngleW   = 24;
   localparam int NumW     = 2 * RadiusW + 5;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;
   localparam int AxisW    = 2;
   localparam int CorrShift = 9;

   localparam logic [GainW-1:0]     GainMin  = GainW'(3277);
   localparam logic [GainW-1:0]     GainMax  = GainW'(6553600);
   localparam logic [GainW-1:0]     GainSat  = GainW'(8388607);
   localparam logic [GainW-1:0]     GainOne  = GainW'(65536);
   localparam logic signed [AngleW:0] SpinFull = (AngleW+1)'(5760000);
   localparam int                   AxisMaxReset = -30000;
   localparam int                   AxisMinReset = 30000;
   localparam logic [AxisW-1:0]     AxisLast = AxisW'(2);

   localparam logic [CosW-1:0]     LevelCosReset    = CosW'(16138);
   localparam logic [CosW-1:0]     NoseDownCosReset = CosW'(1638);
   localparam logic [CosW-1:0]     VertExitCosReset = CosW'(2785);
   localparam logic [TimeoutW-1:0] SpinTimeoutReset = TimeoutW'(15000);
   localparam logic [RadiusW-1:0]  RadiusReset      = RadiusW'(200);

   typedef enum logic [CsrIdxW-1:0] {
      REG_LEVEL_COS  = 3'd0,
      REG_NOSE_COS   = 3'd1,
      REG_VERT_COS   = 3'd2,
      REG_TIMEOUT    = 3'd3,
      REG_RADIUS     = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      STEP_LEVEL_SPIN = 3'd0,
      STEP_LEVEL_ERR  = 3'd1,
      STEP_NOSE_DOWN  = 3'd2,
      STEP_VERT_SPIN  = 3'd3,
      STEP_VERT_ERR   = 3'd4,
      STEP_FINISH     = 3'd5
   } step_type;

   localparam logic [IndW-1:0] IND_IDLE       = 3'd0;
   localparam logic [IndW-1:0] IND_LEVEL_SPIN = 3'd1;
   localparam logic [IndW-1:0] IND_NOSE_DOWN  = 3'd2;
   localparam logic [IndW-1:0] IND_VERT_SPIN  = 3'd3;
   localparam logic [IndW-1:0] IND_TILT_ERR   = 3'd4;

   typedef struct packed {
      logic [CosW-1:0]     level_cos;
      logic [CosW-1:0]     nose_cos;
      logic [CosW-1:0]     vert_cos;
      logic [TimeoutW-1:0] spin_timeout;
      logic [RadiusW-1:0]  radius;
   } cfg_type;

   typedef struct packed {
      logic             capture;
      logic             mul;
      logic             sat;
      logic             div_start;
      logic             div_write;
      logic             step;
      logic             load_out;
      logic [AxisW-1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic finish;
      logic div_busy;
      logic div_done;
      logic out_valid;
   } stat_type;

   function automatic logic [GainW-1:0] clamp_gain(input logic [GainW-1:0] g);
      logic [GainW-1:0] r;
      r = g;
      if (g < GainMin) r = GainMin;
      if (g > GainMax) r = GainMax;
      return r;
   endfunction

endpackage

>>> hdl/mmc_if.sv
// word channels of the calibration core: sample request, result and register write
interface mmc_req_if #(parameter int RAW_BITS = mmc_pkg::RawBitsDefault) ();
   logic                             valid;
   logic                             ready;
   logic signed [RAW_BITS-1:0]       raw_x;
   logic signed [RAW_BITS-1:0]       raw_y;
   logic signed [RAW_BITS-1:0]       raw_z;
   logic signed [mmc_pkg::TiltW-1:0] tilt_cos;
   logic signed [mmc_pkg::RateW-1:0] rate_x;
   logic signed [mmc_pkg::RateW-1:0] rate_z;
   logic [mmc_pkg::TickW-1:0]        tick_ms;
   logic                             armed;
   logic                             start_request;
   modport source (output valid, raw_x, raw_y, raw_z, tilt_cos, rate_x, rate_z, tick_ms,
                   armed, start_request, input ready);
   modport sink (input valid, raw_x, raw_y, raw_z, tilt_cos, rate_x, rate_z, tick_ms,
                 armed, start_request, output ready);
endinterface

interface mmc_rsp_if ();
   logic                             valid;
   logic                             ready;
   logic signed [mmc_pkg::CorrW-1:0] corr_x;
   logic signed [mmc_pkg::CorrW-1:0] corr_y;
   logic signed [mmc_pkg::CorrW-1:0] corr_z;
   logic [mmc_pkg::IndW-1:0]         indicator_code;
   logic                             cal_active;
   logic                             timeout_error;
   logic                             cal_done;
   modport source (output valid, corr_x, corr_y, corr_z, indicator_code, cal_active,
                   timeout_error, cal_done, input ready);
   modport sink (input valid, corr_x, corr_y, corr_z, indicator_code, cal_active,
                 timeout_error, cal_done, output ready);
endinterface

interface mmc_csr_if ();
   logic                           valid;
   logic                           ready;
   logic [mmc_pkg::CsrIdxW-1:0]    index;
   logic [mmc_pkg::CsrDataW-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/mmc_div.sv
// restoring divider, one quotient bit per cycle, for the gain computation
module mmc_div #(
   parameter int DEN_W = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [mmc_pkg::NumW-1:0] num,
   input  logic [DEN_W-1:0]         den,
   output logic                     busy,
   output logic                     done,
   output logic [mmc_pkg::NumW-1:0] quo
);
   localparam int NW   = mmc_pkg::NumW;
   localparam int CntW = $clog2(NW + 1);

   logic [NW-1:0]    num_ff, num_in;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CntW-1:0]  cnt_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   shifted, diff;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, num_ff[NW-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      num_in  = {num_ff[NW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CntW'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = num_ff;
endmodule

>>> hdl/mmc_datapath.sv
// calibration state, correction multiplier, step logic and result register
module mmc_datapath #(
   parameter int RAW_BITS = mmc_pkg::RawBitsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mmc_pkg::cmd_type                 cmd,
   output mmc_pkg::stat_type                stat,
   input  mmc_pkg::cfg_type                 cfg,
   input  logic signed [RAW_BITS-1:0]       raw_x,
   input  logic signed [RAW_BITS-1:0]       raw_y,
   input  logic signed [RAW_BITS-1:0]       raw_z,
   input  logic signed [mmc_pkg::TiltW-1:0] tilt_cos,
   input  logic signed [mmc_pkg::RateW-1:0] rate_x,
   input  logic signed [mmc_pkg::RateW-1:0] rate_z,
   input  logic [mmc_pkg::TickW-1:0]        tick_ms,
   input  logic                             armed,
   input  logic                             start_request,
   input  logic                             div_busy,
   input  logic                             div_done,
   input  logic [mmc_pkg::NumW-1:0]         div_quo,
   output logic [mmc_pkg::NumW-1:0]         div_num,
   output logic [(RAW_BITS > 16 ? RAW_BITS : 16)-1:0] div_den,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic signed [mmc_pkg::CorrW-1:0] corr_x,
   output logic signed [mmc_pkg::CorrW-1:0] corr_y,
   output logic signed [mmc_pkg::CorrW-1:0] corr_z,
   output logic [mmc_pkg::IndW-1:0]         indicator_code,
   output logic                             cal_active,
   output logic                             timeout_error,
   output logic                             cal_done
);
   localparam int AXW = (RAW_BITS > 16) ? RAW_BITS : 16;
   localparam int OFW = AXW + 1;
   localparam int DW  = AXW + 2;
   localparam int PW  = DW + mmc_pkg::GainW + 1;
   localparam int GW  = mmc_pkg::GainW;
   localparam int AW  = mmc_pkg::AngleW;
   localparam int TW  = mmc_pkg::TimeoutW;
   localparam int CW  = mmc_pkg::CorrW;
   localparam logic signed [AXW-1:0] MaxReset = AXW'(mmc_pkg::AxisMaxReset);
   localparam logic signed [AXW-1:0] MinReset = AXW'(mmc_pkg::AxisMinReset);
   localparam logic signed [PW-1:0]  CorrHi = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [PW-1:0]  CorrLo = {{(PW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   // captured word
   logic signed [RAW_BITS-1:0]       raw_ff [3];
   logic signed [mmc_pkg::TiltW-1:0] tilt_ff;
   logic signed [mmc_pkg::RateW-1:0] rate_x_ff, rate_z_ff;
   logic [mmc_pkg::TickW-1:0]        ms_ff;
   logic                             armed_ff;

   // calibration state
   logic signed [AXW-1:0] max_ff [3], max_in [3];
   logic signed [AXW-1:0] min_ff [3], min_in [3];
   logic signed [OFW-1:0] off_ff [3], off_in [3];
   logic [GW-1:0]         gain_ff [3];
   mmc_pkg::step_type     step_ff, step_in;
   logic signed [AW-1:0]  angle_ff [2], angle_in [2];
   logic [TW-1:0]         tcount_ff, tcount_in;
   logic                  latch_ff, latch_in;
   logic [mmc_pkg::IndW-1:0] ind_ff, ind_in;
   logic                  terr_ff, terr_in, done_ff, done_in;

   // correction and spin products
   logic signed [PW-1:0]  prod_ff;
   logic signed [AW-1:0]  spin_prod_ff;
   logic signed [CW-1:0]  corr_ff [3];

   // result register
   logic                  out_valid_ff;
   logic signed [CW-1:0]  out_corr_ff [3];
   logic [mmc_pkg::IndW-1:0] out_ind_ff;
   logic                  out_active_ff, out_terr_ff, out_done_ff;

   logic signed [DW-1:0]  d_val;
   logic signed [GW:0]    g_val;
   logic signed [PW-1:0]  q_val;
   logic signed [CW-1:0]  sat_val;
   logic signed [OFW-1:0] range_val;
   logic signed [AXW-1:0] raw_ext [3];
   logic signed [AW:0]    spin_sum;
   logic                  spun;
   logic [TW:0]           tcount_sum;
   logic [GW-1:0]         gain_new;

   always_comb begin
      for (int i = 0; i < 3; i++) raw_ext[i] = AXW'(raw_ff[i]);
      d_val = DW'($signed({raw_ext[cmd.axis], 1'b0})) - DW'(off_ff[cmd.axis]);
      g_val = $signed({1'b0, mmc_pkg::clamp_gain(gain_ff[cmd.axis])});
      q_val = prod_ff >>> mmc_pkg::CorrShift;
      if (q_val > CorrHi)      sat_val = CorrHi[CW-1:0];
      else if (q_val < CorrLo) sat_val = CorrLo[CW-1:0];
      else                     sat_val = q_val[CW-1:0];
      range_val = OFW'(max_ff[cmd.axis]) - OFW'(min_ff[cmd.axis]);
      if (range_val <= 0)                  gain_new = '0;
      else if (div_quo > mmc_pkg::NumW'(mmc_pkg::GainSat)) gain_new = mmc_pkg::GainSat;
      else                                 gain_new = div_quo[GW-1:0];
   end

   assign div_num = {cfg.radius, 1'b0, 16'd0};
   assign div_den = range_val[AXW-1:0];

   // one tick of the calibration sequence
   always_comb begin
      max_in    = max_ff;
      min_in    = min_ff;
      off_in    = off_ff;
      step_in   = step_ff;
      angle_in  = angle_ff;
      tcount_in = tcount_ff;
      latch_in  = latch_ff;
      ind_in    = ind_ff;
      terr_in   = 1'b0;
      done_in   = 1'b0;
      spin_sum  = (AW+1)'(angle_ff[(step_ff == mmc_pkg::STEP_VERT_SPIN) ? 1 : 0])
                  + (AW+1)'(spin_prod_ff);
      spun      = (spin_sum > mmc_pkg::SpinFull) || (spin_sum < -mmc_pkg::SpinFull);
      tcount_sum = {1'b0, tcount_ff} + (TW+1)'(ms_ff);
      if (latch_ff && !armed_ff) begin
         unique case (step_ff)
            mmc_pkg::STEP_LEVEL_SPIN: begin
               for (int i = 0; i < 2; i++) begin
                  if (raw_ext[i] > max_ff[i]) max_in[i] = raw_ext[i];
                  if (raw_ext[i] < min_ff[i]) min_in[i] = raw_ext[i];
               end
               if (tilt_ff < $signed({1'b0, cfg.level_cos})) begin
                  ind_in      = mmc_pkg::IND_TILT_ERR;
                  step_in     = mmc_pkg::STEP_LEVEL_ERR;
                  angle_in[0] = '0;
               end else begin
                  ind_in      = mmc_pkg::IND_LEVEL_SPIN;
                  angle_in[0] = spun ? '0 : spin_sum[AW-1:0];
                  if (spun) step_in = mmc_pkg::STEP_NOSE_DOWN;
               end
            end
            mmc_pkg::STEP_LEVEL_ERR: begin
               for (int i = 0; i < 2; i++) begin
                  max_in[i] = MaxReset;
                  min_in[i] = MinReset;
               end
               angle_in[0] = '0;
               step_in     = mmc_pkg::STEP_LEVEL_SPIN;
            end
            mmc_pkg::STEP_NOSE_DOWN: begin
               ind_in = mmc_pkg::IND_NOSE_DOWN;
               if (tilt_ff < $signed({1'b0, cfg.nose_cos})) step_in = mmc_pkg::STEP_VERT_SPIN;
            end
            mmc_pkg::STEP_VERT_SPIN: begin
               if (raw_ext[2] > max_ff[2]) max_in[2] = raw_ext[2];
               if (raw_ext[2] < min_ff[2]) min_in[2] = raw_ext[2];
               if (tilt_ff > $signed({1'b0, cfg.vert_cos})) begin
                  ind_in      = mmc_pkg::IND_NOSE_DOWN;
                  step_in     = mmc_pkg::STEP_VERT_ERR;
                  angle_in[1] = '0;
               end else begin
                  ind_in      = mmc_pkg::IND_VERT_SPIN;
                  angle_in[1] = spun ? '0 : spin_sum[AW-1:0];
                  if (spun) step_in = mmc_pkg::STEP_FINISH;
               end
            end
            mmc_pkg::STEP_VERT_ERR: begin
               max_in[2]   = MaxReset;
               min_in[2]   = MinReset;
               angle_in[1] = '0;
               step_in     = mmc_pkg::STEP_NOSE_DOWN;
            end
            mmc_pkg::STEP_FINISH: begin
               for (int i = 0; i < 3; i++) begin
                  off_in[i] = OFW'(max_ff[i]) + OFW'(min_ff[i]);
                  max_in[i] = MaxReset;
                  min_in[i] = MinReset;
               end
               angle_in[0] = '0;
               angle_in[1] = '0;
               step_in     = mmc_pkg::STEP_LEVEL_SPIN;
               latch_in    = 1'b0;
               ind_in      = mmc_pkg::IND_IDLE;
               done_in     = 1'b1;
            end
            default: begin
            end
         endcase
         if (step_in == mmc_pkg::STEP_LEVEL_SPIN || step_in == mmc_pkg::STEP_VERT_SPIN) begin
            if (tcount_ff < cfg.spin_timeout) begin
               tcount_in = tcount_sum[TW] ? '1 : tcount_sum[TW-1:0];
            end else begin
               terr_in   = 1'b1;
               tcount_in = '0;
               ind_in    = mmc_pkg::IND_IDLE;
               latch_in  = 1'b0;
            end
         end else begin
            tcount_in = '0;
         end
      end else begin
         step_in = mmc_pkg::STEP_LEVEL_SPIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            max_ff[i]  <= MaxReset;
            min_ff[i]  <= MinReset;
            off_ff[i]  <= '0;
            gain_ff[i] <= mmc_pkg::GainOne;
         end
         step_ff      <= mmc_pkg::STEP_LEVEL_SPIN;
         angle_ff[0]  <= '0;
         angle_ff[1]  <= '0;
         tcount_ff    <= '0;
         latch_ff     <= 1'b0;
         ind_ff       <= mmc_pkg::IND_IDLE;
         terr_ff      <= 1'b0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture && start_request) latch_ff <= 1'b1;
         if (cmd.div_write) gain_ff[cmd.axis] <= gain_new;
         if (cmd.step) begin
            max_ff    <= max_in;
            min_ff    <= min_in;
            off_ff    <= off_in;
            step_ff   <= step_in;
            angle_ff  <= angle_in;
            tcount_ff <= tcount_in;
            latch_ff  <= latch_in;
            ind_ff    <= ind_in;
            terr_ff   <= terr_in;
            done_ff   <= done_in;
         end
         if (cmd.load_out)      out_valid_ff <= 1'b1;
         else if (rsp_ready)    out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         raw_ff[0] <= raw_x;
         raw_ff[1] <= raw_y;
         raw_ff[2] <= raw_z;
         tilt_ff   <= tilt_cos;
         rate_x_ff <= rate_x;
         rate_z_ff <= rate_z;
         ms_ff     <= tick_ms;
         armed_ff  <= armed;
      end
      if (cmd.mul) begin
         prod_ff <= d_val * g_val;
         if (cmd.axis == '0) begin
            spin_prod_ff <= AW'($signed({1'b0, ms_ff}) *
                            ((step_ff == mmc_pkg::STEP_VERT_SPIN) ? rate_x_ff : rate_z_ff));
         end
      end
      if (cmd.sat) corr_ff[cmd.axis] <= sat_val;
      if (cmd.load_out) begin
         out_corr_ff   <= corr_ff;
         out_ind_ff    <= ind_ff;
         out_active_ff <= latch_ff;
         out_terr_ff   <= terr_ff;
         out_done_ff   <= done_ff;
      end
   end

   assign stat.finish    = latch_ff && !armed_ff && (step_ff == mmc_pkg::STEP_FINISH);
   assign stat.div_busy  = div_busy;
   assign stat.div_done  = div_done;
   assign stat.out_valid = out_valid_ff;

   assign rsp_valid      = out_valid_ff;
   assign corr_x         = out_corr_ff[0];
   assign corr_y         = out_corr_ff[1];
   assign corr_z         = out_corr_ff[2];
   assign indicator_code = out_ind_ff;
   assign cal_active     = out_active_ff;
   assign timeout_error  = out_terr_ff;
   assign cal_done       = out_done_ff;
endmodule

>>> hdl/mmc_ctrl.sv
// sequencer: capture, per-axis correction, gain divisions, step update, result hand-off
module mmc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_ready,
   input  mmc_pkg::stat_type stat,
   output mmc_pkg::cmd_type  cmd
);
   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_MUL       = 7'b0000010,
      S_SAT       = 7'b0000100,
      S_DIV_START = 7'b0001000,
      S_DIV_WAIT  = 7'b0010000,
      S_STEP      = 7'b0100000,
      S_LOAD      = 7'b1000000
   } state_type;

   state_type                 state_ff, state_in;
   logic [mmc_pkg::AxisW-1:0] axis_ff, axis_in;

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      cmd       = '0;
      cmd.axis  = axis_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               axis_in     = '0;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SAT;
         end
         S_SAT: begin
            cmd.sat = 1'b1;
            if (axis_ff == mmc_pkg::AxisLast) begin
               axis_in  = '0;
               state_in = stat.finish ? S_DIV_START : S_STEP;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.div_write = 1'b1;
               if (axis_ff == mmc_pkg::AxisLast) begin
                  state_in = S_STEP;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_DIV_START;
               end
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (!stat.out_valid || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("controller state not one-hot");
   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> stat.div_busy)
      else $error("divider did not start");
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> state_ff == S_DIV_WAIT)
      else $error("divider finished outside the wait state");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> stat.out_valid)
      else $error("result word not presented after load");
endmodule

>>> hdl/magnetometer_minmax_calibration_core.sv
// top level of the magnetometer min/max hard-iron and scale calibration core
// one request word per tick brings the raw samples, tilt cosine, gyro rates, tick length
// and the armed/start flags; one response word returns the corrected field on each axis
// ((raw - offset) * gain in 1/256 units, saturated to 32 bits) plus the step indicator
// and the latch, timeout and done flags. items are handled one at a time: a normal tick
// goes through capture, three multiply/saturate pairs on the one shared correction
// multiplier, one step update and result load; the finish tick adds three divisions on
// the shared restoring divider before the step update. a new word is taken as soon as
// the result is loaded, even while that result still waits.
// configuration registers are written through the csr channel, which is always ready;
// an index past the register list is ignored
module magnetometer_minmax_calibration_core #(
   parameter int RAW_BITS = mmc_pkg::RawBitsDefault
) (
   input logic          clock,
   input logic          reset,
   mmc_req_if.sink      req_ch,
   mmc_rsp_if.source    rsp_ch,
   mmc_csr_if.sink      csr_ch
);
   localparam int AXW = (RAW_BITS > 16) ? RAW_BITS : 16;

   mmc_pkg::cfg_type  cfg_ff;
   mmc_pkg::cmd_type  cmd;
   mmc_pkg::stat_type stat;
   logic                     div_busy, div_done;
   logic [mmc_pkg::NumW-1:0] div_quo, div_num;
   logic [AXW-1:0]           div_den;

   // register file; the user must write it only while the core is idle, the block does not enforce this
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_cos    <= mmc_pkg::LevelCosReset;
         cfg_ff.nose_cos     <= mmc_pkg::NoseDownCosReset;
         cfg_ff.vert_cos     <= mmc_pkg::VertExitCosReset;
         cfg_ff.spin_timeout <= mmc_pkg::SpinTimeoutReset;
         cfg_ff.radius       <= mmc_pkg::RadiusReset;
      end else if (csr_ch.valid) begin
         unique case (mmc_pkg::reg_index_type'(csr_ch.index))
            mmc_pkg::REG_LEVEL_COS: cfg_ff.level_cos    <= csr_ch.data[mmc_pkg::CosW-1:0];
            mmc_pkg::REG_NOSE_COS:  cfg_ff.nose_cos     <= csr_ch.data[mmc_pkg::CosW-1:0];
            mmc_pkg::REG_VERT_COS:  cfg_ff.vert_cos     <= csr_ch.data[mmc_pkg::CosW-1:0];
            mmc_pkg::REG_TIMEOUT:   cfg_ff.spin_timeout <= csr_ch.data;
            mmc_pkg::REG_RADIUS:    cfg_ff.radius       <= csr_ch.data[mmc_pkg::RadiusW-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   mmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // shared gain divider: 2 * radius * 65536 / (max - min)
   mmc_div #(.DEN_W(AXW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   // calibration state and result word
   mmc_datapath #(.RAW_BITS(RAW_BITS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .cfg            (cfg_ff),
      .raw_x          (req_ch.raw_x),
      .raw_y          (req_ch.raw_y),
      .raw_z          (req_ch.raw_z),
      .tilt_cos       (req_ch.tilt_cos),
      .rate_x         (req_ch.rate_x),
      .rate_z         (req_ch.rate_z),
      .tick_ms        (req_ch.tick_ms),
      .armed          (req_ch.armed),
      .start_request  (req_ch.start_request),
      .div_busy       (div_busy),
      .div_done       (div_done),
      .div_quo        (div_quo),
      .div_num        (div_num),
      .div_den        (div_den),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .corr_x         (rsp_ch.corr_x),
      .corr_y         (rsp_ch.corr_y),
      .corr_z         (rsp_ch.corr_z),
      .indicator_code (rsp_ch.indicator_code),
      .cal_active     (rsp_ch.cal_active),
      .timeout_error  (rsp_ch.timeout_error),
      .cal_done       (rsp_ch.cal_done)
   );
endmodule

>>> bench/tb_magnetometer_minmax_calibration_core.sv
// self-checking bench for the magnetometer min/max calibration core
module tb_magnetometer_minmax_calibration_core;

   localparam logic [mmc_pkg::CsrIdxW-1:0] RegNone = 3'd7;   // index past the register list
   localparam int RandomTicks = 1000;

   // one sample word as the sender builds it
   typedef struct {
      logic signed [15:0]        raw_x, raw_y, raw_z, tilt, rate_x, rate_z;
      logic [mmc_pkg::TickW-1:0] tick_ms;
      logic                      armed, start;
   } tick_type;

   // one corrected-field word as the core should return it
   typedef struct {
      logic signed [mmc_pkg::CorrW-1:0] cx, cy, cz;
      logic [mmc_pkg::IndW-1:0]         ind;
      logic                             active, terr, done;
   } field_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mmc_req_if req_ch ();
   mmc_rsp_if rsp_ch ();
   mmc_csr_if csr_ch ();

   magnetometer_minmax_calibration_core u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow registers and calibration state
   int                int_unused_guard;
   int                lvl_cos, nose_cos, vert_cos, spin_limit, radius;
   int                ax_max[3], ax_min[3], offs_half[3];
   int unsigned       gain_q[3];
   mmc_pkg::step_type cal_step;
   int                spin_ang[2];
   int unsigned       tmo_count;
   bit                latch;
   logic [2:0]        ind_reg;

   field_type pending_fields[$];
   int     mismatches = 0;
   bit     send_fast = 1'b0;    // sender without gaps
   bit     sink_fast = 1'b0;    // receiver without stalls
   bit     sink_hold = 1'b0;    // receiver holds off for a long stretch

   // ---------------------------------------------------------------- predictor

   function automatic void cal_reset_state();
      lvl_cos = mmc_pkg::LevelCosReset; nose_cos = mmc_pkg::NoseDownCosReset;
      vert_cos = mmc_pkg::VertExitCosReset;
      spin_limit = mmc_pkg::SpinTimeoutReset; radius = mmc_pkg::RadiusReset;
      for (int i = 0; i < 3; i++) begin
         ax_max[i] = mmc_pkg::AxisMaxReset; ax_min[i] = mmc_pkg::AxisMinReset;
         offs_half[i] = 0; gain_q[i] = mmc_pkg::GainOne;
      end
      cal_step = mmc_pkg::STEP_LEVEL_SPIN; spin_ang[0] = 0; spin_ang[1] = 0;
      tmo_count = 0; latch = 1'b0; ind_reg = mmc_pkg::IND_IDLE;
      int_unused_guard = 0;
   endfunction

   function automatic void clear_axes(input int lo, input int hi);
      for (int i = lo; i <= hi; i++) begin
         ax_max[i] = mmc_pkg::AxisMaxReset; ax_min[i] = mmc_pkg::AxisMinReset;
      end
   endfunction

   function automatic void track_axis(input int i, input int v);
      if (v > ax_max[i]) ax_max[i] = v;
      if (v < ax_min[i]) ax_min[i] = v;
   endfunction

   // integrate one rate; a full turn either way ends the spin and clears the angle
   function automatic bit turn_complete(input int k, input int rate, input int ms);
      int a;
      a = spin_ang[k] + ms * rate;
      spin_ang[k] = a;
      if (a > int'(mmc_pkg::SpinFull) || a < -int'(mmc_pkg::SpinFull)) begin
         spin_ang[k] = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // (raw - offset) * gain in 1/256 units, floor rounding, saturated
   function automatic logic signed [31:0] corrected(input int raw, input int i);
      longint p, q;
      p = (longint'(raw) * 2 - longint'(offs_half[i])) * longint'(gain_q[i]);
      q = p >>> mmc_pkg::CorrShift;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   function automatic field_type predict_fields(input tick_type t);
      field_type   r;
      int          raw[3];
      int          tilt, ms, rng;
      longint unsigned quo;
      bit          terr, done;
      raw[0] = t.raw_x; raw[1] = t.raw_y; raw[2] = t.raw_z;
      tilt = t.tilt; ms = t.tick_ms;
      terr = 1'b0; done = 1'b0;
      if (t.start) latch = 1'b1;
      // gains are clamped every tick before use
      for (int i = 0; i < 3; i++) begin
         if (gain_q[i] < mmc_pkg::GainMin) gain_q[i] = mmc_pkg::GainMin;
         if (gain_q[i] > mmc_pkg::GainMax) gain_q[i] = mmc_pkg::GainMax;
      end
      r.cx = corrected(raw[0], 0);
      r.cy = corrected(raw[1], 1);
      r.cz = corrected(raw[2], 2);
      if (latch && !t.armed) begin
         case (cal_step)
            mmc_pkg::STEP_LEVEL_SPIN: begin
               track_axis(0, raw[0]); track_axis(1, raw[1]);
               if (tilt < lvl_cos) begin
                  ind_reg = mmc_pkg::IND_TILT_ERR; cal_step = mmc_pkg::STEP_LEVEL_ERR;
                  spin_ang[0] = 0;
               end else begin
                  ind_reg = mmc_pkg::IND_LEVEL_SPIN;
                  if (turn_complete(0, t.rate_z, ms)) cal_step = mmc_pkg::STEP_NOSE_DOWN;
               end
            end
            mmc_pkg::STEP_LEVEL_ERR: begin
               clear_axes(0, 1); spin_ang[0] = 0; cal_step = mmc_pkg::STEP_LEVEL_SPIN;
            end
            mmc_pkg::STEP_NOSE_DOWN: begin
               ind_reg = mmc_pkg::IND_NOSE_DOWN;
               if (tilt < nose_cos) cal_step = mmc_pkg::STEP_VERT_SPIN;
            end
            mmc_pkg::STEP_VERT_SPIN: begin
               track_axis(2, raw[2]);
               if (tilt > vert_cos) begin
                  ind_reg = mmc_pkg::IND_NOSE_DOWN; cal_step = mmc_pkg::STEP_VERT_ERR;
                  spin_ang[1] = 0;
               end else begin
                  ind_reg = mmc_pkg::IND_VERT_SPIN;
                  if (turn_complete(1, t.rate_x, ms)) cal_step = mmc_pkg::STEP_FINISH;
               end
            end
            mmc_pkg::STEP_VERT_ERR: begin
               clear_axes(2, 2); spin_ang[1] = 0; cal_step = mmc_pkg::STEP_NOSE_DOWN;
            end
            mmc_pkg::STEP_FINISH: begin
               for (int i = 0; i < 3; i++) begin
                  rng = ax_max[i] - ax_min[i];
                  offs_half[i] = ax_max[i] + ax_min[i];
                  if (rng <= 0) begin
                     gain_q[i] = 0;
                  end else begin
                     quo = ((longint'(radius) * 2) << 16) / rng;
                     gain_q[i] = (quo > mmc_pkg::GainSat) ? mmc_pkg::GainSat : quo;
                  end
               end
               clear_axes(0, 2);
               spin_ang[0] = 0; spin_ang[1] = 0;
               cal_step = mmc_pkg::STEP_LEVEL_SPIN; latch = 1'b0;
               ind_reg = mmc_pkg::IND_IDLE; done = 1'b1;
            end
            default: ;
         endcase
         // spin steps run against the time limit
         if (cal_step == mmc_pkg::STEP_LEVEL_SPIN || cal_step == mmc_pkg::STEP_VERT_SPIN) begin
            if (tmo_count < spin_limit) begin
               tmo_count += ms;
               if (tmo_count > 32'hFFFF) tmo_count = 32'hFFFF;
            end else begin
               terr = 1'b1; tmo_count = 0; ind_reg = mmc_pkg::IND_IDLE; latch = 1'b0;
            end
         end else begin
            tmo_count = 0;
         end
      end else begin
         cal_step = mmc_pkg::STEP_LEVEL_SPIN;
      end
      r.ind = ind_reg; r.active = latch; r.terr = terr; r.done = done;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   // offer one word after a random gap and file its expected fields once taken
   task automatic send_tick(input tick_type t);
      int gap;
      gap = send_fast ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.raw_x         <= t.raw_x;
      req_ch.raw_y         <= t.raw_y;
      req_ch.raw_z         <= t.raw_z;
      req_ch.tilt_cos      <= t.tilt;
      req_ch.rate_x        <= t.rate_x;
      req_ch.rate_z        <= t.rate_z;
      req_ch.tick_ms       <= t.tick_ms;
      req_ch.armed         <= t.armed;
      req_ch.start_request <= t.start;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_fields.push_back(predict_fields(t));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // registers are only written with the core idle
   task automatic write_reg(input logic [mmc_pkg::CsrIdxW-1:0] idx, input int value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value[mmc_pkg::CsrDataW-1:0];
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      case (idx)
         mmc_pkg::REG_LEVEL_COS: lvl_cos = value & 32'h7FFF;
         mmc_pkg::REG_NOSE_COS:  nose_cos = value & 32'h7FFF;
         mmc_pkg::REG_VERT_COS:  vert_cos = value & 32'h7FFF;
         mmc_pkg::REG_TIMEOUT:   spin_limit = value & 32'hFFFF;
         mmc_pkg::REG_RADIUS:    radius = value & 32'hFFF;
         default: ;
      endcase
   endtask

   task automatic write_all(input int lc, input int nc, input int vc, input int tm,
                            input int rd);
      wait_drained();
      write_reg(mmc_pkg::REG_LEVEL_COS, lc);
      write_reg(mmc_pkg::REG_NOSE_COS, nc);
      write_reg(mmc_pkg::REG_VERT_COS, vc);
      write_reg(mmc_pkg::REG_TIMEOUT, tm);
      write_reg(mmc_pkg::REG_RADIUS, rd);
   endtask

   function automatic tick_type make_tick(input int rx, input int ry, input int rz,
                                          input int tilt, input int ratex, input int ratez,
                                          input int ms, input bit armed, input bit start);
      tick_type t;
      t.raw_x = rx; t.raw_y = ry; t.raw_z = rz; t.tilt = tilt;
      t.rate_x = ratex; t.rate_z = ratez; t.tick_ms = ms; t.armed = armed; t.start = start;
      return t;
   endfunction

   function automatic int rand_s16();
      return int'($signed(16'($urandom())));
   endfunction

   // random rate: often a full turn takes several ticks, sometimes one
   function automatic int rand_rate();
      case ($urandom_range(0, 3))
         0: return rand_s16();
         1: return $urandom_range(0, 1) ? 32767 : -32768;
         default: return int'($urandom_range(0, 3000)) - 1500;
      endcase
   endfunction

   // raw samples sometimes spread over the full range, mostly near one point
   function automatic int rand_raw(input int centre, input int spread);
      int v;
      if ($urandom_range(0, 9) == 0) return rand_s16();
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   // a word steered by the predicted step so that whole calibrations go through
   function automatic tick_type steered_tick(input int spread);
      tick_type t;
      int       tilt, ms;
      ms = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(10, 60);
      case (cal_step)
         mmc_pkg::STEP_LEVEL_SPIN:
            tilt = $urandom_range(0, 11) == 0 ? int'($urandom_range(0, 32768)) - 16384
                                              : $urandom_range(lvl_cos, 16384);
         mmc_pkg::STEP_NOSE_DOWN, mmc_pkg::STEP_VERT_SPIN:
            tilt = $urandom_range(0, 11) == 0 ? int'($urandom_range(0, 32768)) - 16384
                                              : int'($urandom_range(0, 3000)) - 1500;
         default: tilt = int'($urandom_range(0, 32768)) - 16384;
      endcase
      t = make_tick(rand_raw(400, spread), rand_raw(-900, spread), rand_raw(150, spread),
                    tilt, rand_rate(), rand_rate(), ms, $urandom_range(0, 24) == 0,
                    latch ? $urandom_range(0, 9) == 0 : $urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) == 0) begin
         // plain noise
         t = make_tick(rand_s16(), rand_s16(), rand_s16(), int'($urandom_range(0, 32768)) - 16384,
                       rand_s16(), rand_s16(), $urandom_range(0, 255), $urandom_range(0, 1),
                       $urandom_range(0, 1));
      end
      return t;
   endfunction

   task automatic send_random(input int count);
      int spread;
      spread = 2000;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) spread = $urandom_range(0, 3) == 0 ? $urandom_range(0, 20)
                                                            : $urandom_range(50, 25000);
         send_tick(steered_tick(spread));
      end
   endtask

   // ---------------------------------------------------------------- tests

   // field extremes with no calibration running
   task automatic test_field_extremes();
      send_tick(make_tick(32767, -32768, 0, 16384, 32767, -32768, 255, 1'b0, 1'b0));
      send_tick(make_tick(-32768, 32767, -1, -16384, -32768, 32767, 0, 1'b1, 1'b0));
      send_tick(make_tick(0, 0, 32767, 0, 0, 0, 1, 1'b0, 1'b0));
   endtask

   // one full calibration, then the tilt errors, arming and the time limit
   task automatic test_calibration_steps();
      // level spin done in one tick, nose down, vertical spin, finish
      send_tick(make_tick(1200, -300, 50, 16384, 0, 32767, 255, 1'b0, 1'b1));
      send_tick(make_tick(-800, 700, 60, 16384, 0, 100, 20, 1'b0, 1'b0));
      send_tick(make_tick(0, 0, 0, 0, 0, 0, 20, 1'b0, 1'b0));
      send_tick(make_tick(0, 0, 900, 0, -32768, 0, 255, 1'b0, 1'b0));
      send_tick(make_tick(0, 0, -500, 0, 0, 0, 20, 1'b0, 1'b0));
      // new gains and offsets in use; z saw one sample so its range is zero
      send_tick(make_tick(32767, -32768, 32767, 16384, 0, 0, 20, 1'b0, 1'b0));
      // level tilt error and its restart, vertical tilt error and its restart
      send_tick(make_tick(100, 100, 100, 16384, 0, 500, 20, 1'b0, 1'b1));
      send_tick(make_tick(100, 100, 100, 100, 0, 500, 20, 1'b0, 1'b0));
      send_tick(make_tick(100, 100, 100, 16384, 0, 500, 20, 1'b0, 1'b0));
      send_tick(make_tick(-100, -100, 100, 16384, 0, -32768, 255, 1'b0, 1'b0));
      send_tick(make_tick(0, 0, 0, -16384, 0, 0, 20, 1'b0, 1'b0));
      send_tick(make_tick(0, 0, 300, 16384, 0, 0, 20, 1'b0, 1'b0));
      send_tick(make_tick(0, 0, 300, 16384, 0, 0, 20, 1'b0, 1'b0));
      send_tick(make_tick(0, 0, 300, 0, 0, 0, 20, 1'b0, 1'b0));
      // armed holds the step at the level spin
      send_tick(make_tick(0, 0, 300, 0, 1000, 0, 20, 1'b1, 1'b0));
      // spin too slow: the time limit ends the calibration
      for (int i = 0; i < 62; i++)
         send_tick(make_tick(10, 10, 10, 16384, 0, 1, 255, 1'b0, 1'b0));
      send_tick(make_tick(10, 10, 10, 16384, 0, 1, 255, 1'b0, 1'b0));
   endtask

   // register settings including the extremes, each followed by random calibrations, then the reset values
   task automatic test_register_settings();
      write_all(0, 16384, 0, 0, 1);
      write_reg(RegNone, 16'hFFFF);
      send_random(25);
      write_all(16384, 0, 16384, 65535, 4095);
      send_random(25);
      write_all(8000, 5000, 9000, 300, 7);
      send_random(25);
      write_all(mmc_pkg::LevelCosReset, mmc_pkg::NoseDownCosReset, mmc_pkg::VertExitCosReset,
                mmc_pkg::SpinTimeoutReset, mmc_pkg::RadiusReset);
   endtask

   // core fills up while the receiver holds off, then the sender waits it out
   task automatic test_backpressure();
      sink_hold = 1'b1;
      send_fast = 1'b1;
      send_random(20);
      send_fast = 1'b0;
      wait_drained();
      send_random(15);
   endtask

   task automatic test_random_traffic();
      send_random(RandomTicks / 2);
      // a stretch with no idling on either side
      send_fast = 1'b1; sink_fast = 1'b1;
      send_random(100);
      send_fast = 1'b0; sink_fast = 1'b0;
      send_random(RandomTicks / 2 - 100);
   endtask

   // ---------------------------------------------------------------- receiver

   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      forever begin
         if (sink_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
            sink_hold = 1'b0;
         end
         stall = sink_fast ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid || reset) @(posedge clock);
      end
   end

   function automatic void compare_field(input string name, input logic signed [31:0] exp_v,
                                         input logic signed [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t %s expected %0d got %0d", $time, name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   // each accepted word against the oldest expectation
   always @(posedge clock) begin
      field_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_fields.size() == 0) begin
            $display("%0t unexpected word, expected none got corr_x %0d", $time,
                     rsp_ch.corr_x);
            mismatches++;
         end else begin
            e = pending_fields.pop_front();
            compare_field("corr_x", e.cx, rsp_ch.corr_x);
            compare_field("corr_y", e.cy, rsp_ch.corr_y);
            compare_field("corr_z", e.cz, rsp_ch.corr_z);
            compare_field("indicator_code", e.ind, rsp_ch.indicator_code);
            compare_field("cal_active", e.active, rsp_ch.cal_active);
            compare_field("timeout_error", e.terr, rsp_ch.timeout_error);
            compare_field("cal_done", e.done, rsp_ch.cal_done);
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.raw_x <= '0; req_ch.raw_y <= '0; req_ch.raw_z <= '0;
      req_ch.tilt_cos <= '0; req_ch.rate_x <= '0; req_ch.rate_z <= '0;
      req_ch.tick_ms <= '0; req_ch.armed <= 1'b0; req_ch.start_request <= 1'b0;
      csr_ch.valid <= 1'b0; csr_ch.index <= '0; csr_ch.data <= '0;
      cal_reset_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_calibration_steps();
      test_register_settings();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      repeat (150) @(posedge clock);
      if (mismatches == 0 && int_unused_guard == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
